@@ design/fre_pkg.sv @@
// ----------------------------------------------------------------------------
// fre_pkg: shared constants and types for the exact float remainder
// Format constants, pipeline word layout and derived widths.
// ----------------------------------------------------------------------------
package fre_pkg;

    localparam int MANT_BITS = 40;
    localparam int EXP_SPAN  = 128;
    localparam int EXP_W     = $clog2(EXP_SPAN);
    localparam int NSTEP     = MANT_BITS + EXP_SPAN - 1;
    localparam int CNT_W     = $clog2(NSTEP + 1);
    localparam int LZ_W      = $clog2(MANT_BITS + 1);
    localparam int DIV_W     = MANT_BITS + 1;

    // word carried through the compare-subtract chain
    typedef struct packed {
        logic                    valid;
        logic                    sign;
        logic                    zero;   // result forced to zero
        logic                    dom;    // zero divisor
        logic signed [EXP_W-1:0] re;
        logic [CNT_W-1:0]        cnt;    // steps still to run
        logic [MANT_BITS-1:0]    q;      // dividend bits, MSB next
        logic [DIV_W-1:0]        d;      // aligned divisor
        logic [DIV_W-1:0]        r;      // partial remainder
    } t_stage;

    // word between the two normalise stages
    typedef struct packed {
        logic                    valid;
        logic                    sign;
        logic                    zero;
        logic                    dom;
        logic signed [EXP_W-1:0] re;
        logic [LZ_W-1:0]         sh;
        logic [MANT_BITS-1:0]    m;
    } t_norm;

endpackage

@@ design/float_remainder_exact_top.sv @@
// ----------------------------------------------------------------------------
// float_remainder_exact_top: exact floating-point remainder
// x - n*y with n truncated, sign of x, renormalised, no rounding.
//
//  channel   | handshake          | word
//  ----------+--------------------+--------------------------------------------
//  operands  | start, busy        | i_x_sign/exp/mant, i_y_sign/exp/mant
//  result    | o_done (strobe)    | o_r_sign, o_r_exp, o_r_mant, o_domain_error
//
// One word enters per cycle; busy is always low.
// Stages: one alignment stage, one stage per compare-subtract step of the
// chain (mantissa bits plus largest exponent gap), two normalise stages.
// The step chain sets the depth.
// Synchronous active-low reset clears only the valid bits; nothing in flight
// survives it. The receiver cannot stall, so o_done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module float_remainder_exact_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_x_sign,
    input  logic signed [fre_pkg::EXP_W-1:0]  i_x_exp,
    input  logic [fre_pkg::MANT_BITS-1:0]     i_x_mant,
    input  logic                              i_y_sign,
    input  logic signed [fre_pkg::EXP_W-1:0]  i_y_exp,
    input  logic [fre_pkg::MANT_BITS-1:0]     i_y_mant,
    output logic                              o_done,
    output logic                              o_r_sign,
    output logic signed [fre_pkg::EXP_W-1:0]  o_r_exp,
    output logic [fre_pkg::MANT_BITS-1:0]     o_r_mant,
    output logic                              o_domain_error
);
    localparam int LAT = fre_pkg::NSTEP + 3;

    fre_pkg::t_stage s_prep, s_chain;
    logic            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // divisor sign has no bearing on the remainder
    fre_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_x_sign (i_x_sign),
        .i_x_exp  (i_x_exp),
        .i_x_mant (i_x_mant),
        .i_y_exp  (i_y_exp),
        .i_y_mant (i_y_mant),
        .o_stage  (s_prep)
    );

    fre_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s_prep),
        .o_stage (s_chain)
    );

    fre_norm u_norm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (s_chain),
        .o_done         (o_done),
        .o_r_sign       (o_r_sign),
        .o_r_exp        (o_r_exp),
        .o_r_mant       (o_r_mant),
        .o_domain_error (o_domain_error)
    );

    // every accepted word comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("result strobe missing");

    // zero divisor always gives an exact zero
    a_dom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_domain_error) |-> (o_r_mant == '0 && o_r_sign == 1'b0))
        else $error("domain error with nonzero result");

    // nonzero results are normalised unless at the exponent floor
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_r_mant != '0) |->
        (o_r_mant[fre_pkg::MANT_BITS-1] ||
         o_r_exp == fre_pkg::EXP_W'(-(fre_pkg::EXP_SPAN / 2))))
        else $error("result not normalised");

    // zero result has zero exponent and sign
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_r_mant == '0) |-> (o_r_exp == '0 && !o_r_sign))
        else $error("zero result not clean");

endmodule

@@ design/fre_prep.sv @@
// ----------------------------------------------------------------------------
// fre_prep: operand alignment
// Picks the remainder exponent, aligns the divisor and sets the step count.
// ----------------------------------------------------------------------------
module fre_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_x_sign,
    input  logic signed [fre_pkg::EXP_W-1:0]    i_x_exp,
    input  logic [fre_pkg::MANT_BITS-1:0]       i_x_mant,
    input  logic signed [fre_pkg::EXP_W-1:0]    i_y_exp,
    input  logic [fre_pkg::MANT_BITS-1:0]       i_y_mant,
    output fre_pkg::t_stage                     o_stage
);
    localparam int MB = fre_pkg::MANT_BITS;
    localparam int EW = fre_pkg::EXP_W;

    fre_pkg::t_stage       r_stage, n_stage;
    logic signed [EW:0]    dxy;
    logic [EW:0]           dyx;
    logic [2*MB-1:0]       wide;
    logic                  ge, fits;

    always_comb begin
        dxy  = (EW+1)'(i_x_exp) - (EW+1)'(i_y_exp);
        dyx  = $unsigned(-dxy);
        ge   = !dxy[EW];
        wide = {{MB{1'b0}}, i_y_mant} << dyx;
        fits = (dyx < (EW+1)'(MB)) && (wide[2*MB-1:MB] == '0);

        n_stage       = '0;
        n_stage.valid = i_valid;
        n_stage.sign  = i_x_sign;
        n_stage.dom   = (i_y_mant == '0);
        n_stage.zero  = (i_y_mant == '0) || (i_x_mant == '0);
        n_stage.q     = i_x_mant;
        n_stage.r     = '0;
        if (ge) begin
            n_stage.re  = i_y_exp;
            n_stage.d   = {1'b0, i_y_mant};
            n_stage.cnt = fre_pkg::CNT_W'(MB) + fre_pkg::CNT_W'($unsigned(dxy));
        end else begin
            n_stage.re  = i_x_exp;
            n_stage.d   = fits ? {1'b0, wide[MB-1:0]} : {1'b1, {MB{1'b0}}};
            n_stage.cnt = fre_pkg::CNT_W'(MB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ design/fre_step.sv @@
// ----------------------------------------------------------------------------
// fre_step: one compare-subtract step
// Shifts in the next dividend bit and takes off the divisor when it fits.
// ----------------------------------------------------------------------------
module fre_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fre_pkg::t_stage i_stage,
    output fre_pkg::t_stage o_stage
);
    localparam int MB = fre_pkg::MANT_BITS;
    localparam int DW = fre_pkg::DIV_W;

    fre_pkg::t_stage r_stage, n_stage;
    logic [DW:0]     t;

    always_comb begin
        n_stage = i_stage;
        t       = {i_stage.r, i_stage.q[MB-1]};
        if (i_stage.cnt != '0) begin
            if (t >= {1'b0, i_stage.d}) begin
                n_stage.r = DW'(t - {1'b0, i_stage.d});
            end else begin
                n_stage.r = t[DW-1:0];
            end
            n_stage.q   = {i_stage.q[MB-2:0], 1'b0};
            n_stage.cnt = i_stage.cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ design/fre_chain.sv @@
// ----------------------------------------------------------------------------
// fre_chain: compare-subtract pipeline
// One registered step per stage, enough stages for the widest exponent gap.
// ----------------------------------------------------------------------------
module fre_chain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fre_pkg::t_stage i_stage,
    output fre_pkg::t_stage o_stage
);
    fre_pkg::t_stage pipe [fre_pkg::NSTEP+1];

    assign pipe[0] = i_stage;

    for (genvar g = 0; g < fre_pkg::NSTEP; g++) begin : g_step
        fre_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (pipe[g]),
            .o_stage (pipe[g+1])
        );
    end

    assign o_stage = pipe[fre_pkg::NSTEP];

endmodule

@@ design/fre_norm.sv @@
// ----------------------------------------------------------------------------
// fre_norm: renormalise
// Leading-zero count with exponent floor, then shift and output register.
// ----------------------------------------------------------------------------
module fre_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fre_pkg::t_stage                   i_stage,
    output logic                              o_done,
    output logic                              o_r_sign,
    output logic signed [fre_pkg::EXP_W-1:0]  o_r_exp,
    output logic [fre_pkg::MANT_BITS-1:0]     o_r_mant,
    output logic                              o_domain_error
);
    localparam int MB = fre_pkg::MANT_BITS;
    localparam int EW = fre_pkg::EXP_W;
    localparam int LW = fre_pkg::LZ_W;
    localparam int CW = LW + EW;

    fre_pkg::t_norm       r_nrm, n_nrm;
    logic [MB-1:0]        m;
    logic [LW-1:0]        lz;
    logic [EW-1:0]        lim;
    logic                 zr;
    logic                 r_done, r_sign, r_dom;
    logic signed [EW-1:0] r_exp;
    logic [MB-1:0]        r_mant;
    logic signed [EW:0]   exp_sh;

    // stage 1: shift amount, limited so the exponent stays at or above the floor
    always_comb begin
        m   = i_stage.r[MB-1:0];
        lz  = LW'(MB);
        for (int i = 0; i < MB; i++) begin
            if (m[i]) begin
                lz = LW'(MB - 1 - i);
            end
        end
        lim = {~i_stage.re[EW-1], i_stage.re[EW-2:0]};
        zr  = i_stage.zero || (m == '0);

        n_nrm       = '0;
        n_nrm.valid = i_stage.valid;
        n_nrm.sign  = i_stage.sign;
        n_nrm.zero  = zr;
        n_nrm.dom   = i_stage.dom;
        n_nrm.re    = i_stage.re;
        n_nrm.m     = m;
        n_nrm.sh    = (CW'(lz) <= CW'(lim)) ? lz : LW'(lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm.valid <= 1'b0;
        end else begin
            r_nrm <= n_nrm;
        end
    end

    // stage 2: shift and output register
    assign exp_sh = (EW+1)'(r_nrm.re) - (EW+1)'($signed({1'b0, r_nrm.sh}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_nrm.valid;
        end
        r_dom  <= r_nrm.dom;
        if (r_nrm.zero) begin
            r_sign <= 1'b0;
            r_exp  <= '0;
            r_mant <= '0;
        end else begin
            r_sign <= r_nrm.sign;
            r_exp  <= exp_sh[EW-1:0];
            r_mant <= r_nrm.m << r_nrm.sh;
        end
    end

    assign o_done         = r_done;
    assign o_r_sign       = r_sign;
    assign o_r_exp        = r_exp;
    assign o_r_mant       = r_mant;
    assign o_domain_error = r_dom;

endmodule
